// File: hw/rtl/lapseq_pkg.sv
`timescale 1ns / 1ps
// Types, codes and small lookup functions for the LED alert pulse sequencer.
// No dependencies; used by the channel interfaces, the top level and the checker.
package lapseq_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_KEYWORD = 2'd1,
    CMD_ACK     = 2'd2,
    CMD_TEST    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    AW_BACKGROUND = 3'd0,
    AW_NOTICE     = 3'd1,
    AW_CANDIDATE  = 3'd2,
    AW_EVENT      = 3'd3,
    AW_COOLDOWN   = 3'd4
  } awareness_e;

  typedef enum logic [1:0] {
    URG_LOW      = 2'd0,
    URG_MEDIUM   = 2'd1,
    URG_HIGH     = 2'd2,
    URG_CRITICAL = 2'd3
  } urgency_e;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_FIXED = 2'd1,
    PK_CONT  = 2'd2
  } pulse_kind_e;

  typedef enum logic [3:0] {
    PAT_NONE      = 4'd0,
    PAT_KEYWORD   = 4'd1,
    PAT_NOTICE    = 4'd2,
    PAT_CANDIDATE = 4'd3,
    PAT_LOW       = 4'd4,
    PAT_MEDIUM    = 4'd5,
    PAT_HIGH      = 4'd6,
    PAT_CRITICAL  = 4'd7,
    PAT_MANUAL    = 4'd8
  } pattern_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVEL_VERY_LOW   = 3'd0,
    REG_LEVEL_DIM        = 3'd1,
    REG_LEVEL_MEDIUM     = 3'd2,
    REG_LEVEL_BRIGHT     = 3'd3,
    REG_KEYWORD_FLASH_MS = 3'd4,
    REG_UNKNOWN_FLASH_MS = 3'd5,
    REG_HALF_PERIOD_MS   = 3'd6
  } cfg_reg_e;

  localparam logic [3:0] DirUnknown = 4'd9;
  localparam logic [3:0] MaskAll    = 4'hF;

  // Confidence thresholds in Q0.8: 0.30, 0.50, 0.75
  localparam logic [7:0] ConfVeryLow = 8'd77;
  localparam logic [7:0] ConfDim     = 8'd128;
  localparam logic [7:0] ConfMedium  = 8'd192;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [3:0]  direction;
    logic [7:0]  confidence;
    logic [2:0]  awareness;
    logic [1:0]  urgency;
    logic        event_fresh;
    logic        notice_fresh;
    logic [7:0]  test_char;
  } in_item_t;

  typedef struct packed {
    logic [3:0] led_mask;
    logic [7:0] led_level;
    logic       drive_valid;
    logic       accepted;
    logic       manual_on;
    logic [3:0] pattern_code;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic       known;  // character recognised
    logic       light;  // character lights LEDs (all but '0')
    logic [3:0] mask;
  } test_dec_t;

  function automatic logic [3:0] dir_mask(input logic [3:0] dir);
    logic [3:0] m;
    unique case (dir)
      4'd0:    m = 4'b0001;
      4'd1:    m = 4'b0010;
      4'd2:    m = 4'b0100;
      4'd3:    m = 4'b1000;
      4'd4:    m = 4'b0011;
      4'd5:    m = 4'b0110;
      4'd6:    m = 4'b1100;
      4'd7:    m = 4'b1001;
      4'd8:    m = 4'b1111;
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

  function automatic test_dec_t test_decode(input logic [7:0] c);
    test_dec_t d;
    d.known = 1'b1;
    d.light = 1'b1;
    d.mask  = 4'b0000;
    unique case (c)
      "F", "1": d.mask = 4'b0001;
      "R", "2": d.mask = 4'b0010;
      "B", "3": d.mask = 4'b0100;
      "L", "4": d.mask = 4'b1000;
      "5":      d.mask = 4'b0011;
      "6":      d.mask = 4'b0110;
      "7":      d.mask = 4'b1100;
      "8":      d.mask = 4'b1001;
      "A", "9": d.mask = 4'b1111;
      "0":      d.light = 1'b0;
      default: begin
        d.known = 1'b0;
        d.light = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/lapseq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the LED alert pulse sequencer.
// Depends on lapseq_pkg for the payload types.
interface lapseq_in_if import lapseq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lapseq_out_if import lapseq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lapseq_cfg_if import lapseq_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/led_alert_pulse_sequencer.sv
`timescale 1ns / 1ps
// LED alert pulse sequencer: takes one item per cycle and returns one result per item,
// passing it through an input register, then a result register. The
// sequencer state is updated as an item moves from the input register to the result
// register, so a new item can follow in every cycle. Both registers stall only when
// the result consumer holds ready low. Config writes are always taken (ready high).
// Depends on lapseq_pkg and lapseq_if.
module led_alert_pulse_sequencer import lapseq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lapseq_cfg_if.sink  cfg_chan,
  lapseq_in_if.sink   in_chan,
  lapseq_out_if.source out_chan
);

  // Config registers
  logic [7:0]  lvl_very_low_q, lvl_dim_q, lvl_medium_q, lvl_bright_q;
  logic [15:0] kw_flash_ms_q, unk_flash_ms_q, half_period_ms_q;

  // Sequencer state
  logic        manual_q, manual_d;
  pulse_kind_e pk_q, pk_d;
  logic [1:0]  pulses_left_q, pulses_left_d;
  logic        phase_q, phase_d;
  logic [31:0] toggle_time_q, toggle_time_d;
  logic        unk_flag_q, unk_flag_d;
  logic [31:0] unk_time_q, unk_time_d;
  logic        kw_flag_q, kw_flag_d;
  logic [31:0] kw_time_q, kw_time_d;
  logic        acked_q, acked_d;
  pattern_e    pat_q, pat_d;

  // Pipeline
  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q, res_d;
  logic      adv;

  assign adv            = in_vld_q && (!out_vld_q || out_chan.ready);
  assign in_chan.ready  = !in_vld_q || adv;
  assign out_chan.valid = out_vld_q;
  assign out_chan.data  = out_q;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_very_low_q   <= 8'd32;
      lvl_dim_q        <= 8'd96;
      lvl_medium_q     <= 8'd160;
      lvl_bright_q     <= 8'd255;
      kw_flash_ms_q    <= 16'd500;
      unk_flash_ms_q   <= 16'd300;
      half_period_ms_q <= 16'd150;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.addr)
        REG_LEVEL_VERY_LOW:   lvl_very_low_q   <= cfg_chan.data.wdata[7:0];
        REG_LEVEL_DIM:        lvl_dim_q        <= cfg_chan.data.wdata[7:0];
        REG_LEVEL_MEDIUM:     lvl_medium_q     <= cfg_chan.data.wdata[7:0];
        REG_LEVEL_BRIGHT:     lvl_bright_q     <= cfg_chan.data.wdata[7:0];
        REG_KEYWORD_FLASH_MS: kw_flash_ms_q    <= cfg_chan.data.wdata;
        REG_UNKNOWN_FLASH_MS: unk_flash_ms_q   <= cfg_chan.data.wdata;
        REG_HALF_PERIOD_MS:   half_period_ms_q <= cfg_chan.data.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        in_vld_q <= in_chan.valid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      in_q <= in_chan.data;
    end
    if (adv) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q      <= 1'b0;
      pk_q          <= PK_NONE;
      pulses_left_q <= 2'd0;
      phase_q       <= 1'b0;
      toggle_time_q <= 32'd0;
      unk_flag_q    <= 1'b0;
      unk_time_q    <= 32'd0;
      kw_flag_q     <= 1'b0;
      kw_time_q     <= 32'd0;
      acked_q       <= 1'b0;
      pat_q         <= PAT_NONE;
    end else if (adv) begin
      manual_q      <= manual_d;
      pk_q          <= pk_d;
      pulses_left_q <= pulses_left_d;
      phase_q       <= phase_d;
      toggle_time_q <= toggle_time_d;
      unk_flag_q    <= unk_flag_d;
      unk_time_q    <= unk_time_d;
      kw_flag_q     <= kw_flag_d;
      kw_time_q     <= kw_time_d;
      acked_q       <= acked_d;
      pat_q         <= pat_d;
    end
  end

  // Item decode
  logic [31:0] now;
  logic [3:0]  dmask;
  logic [7:0]  bright;
  test_dec_t   tdec;
  logic        kw_live;

  assign now   = in_q.now_ms;
  assign dmask = dir_mask(in_q.direction);
  assign tdec  = test_decode(in_q.test_char);
  assign kw_live = (now - kw_time_q) < {16'd0, kw_flash_ms_q};

  always_comb begin
    if (in_q.confidence < ConfVeryLow) begin
      bright = lvl_very_low_q;
    end else if (in_q.confidence < ConfDim) begin
      bright = lvl_dim_q;
    end else if (in_q.confidence < ConfMedium) begin
      bright = lvl_medium_q;
    end else begin
      bright = lvl_bright_q;
    end
  end

  // Next state and result for the item in the input register
  always_comb begin
    logic       done;
    logic [3:0] mask;
    logic [7:0] level;
    logic       drive;
    logic       acc;

    manual_d      = manual_q;
    pk_d          = pk_q;
    pulses_left_d = pulses_left_q;
    phase_d       = phase_q;
    toggle_time_d = toggle_time_q;
    unk_flag_d    = unk_flag_q;
    unk_time_d    = unk_time_q;
    kw_flag_d     = kw_flag_q;
    kw_time_d     = kw_time_q;
    acked_d       = acked_q;
    pat_d         = pat_q;
    done          = 1'b0;
    mask          = 4'd0;
    level         = 8'd0;
    drive         = 1'b0;
    acc           = 1'b1;

    unique case (cmd_e'(in_q.command))
      CMD_UPDATE: begin
        if (!manual_q) begin
          drive = 1'b1;
          if (kw_flag_q) begin
            if (kw_live) begin
              mask  = MaskAll;
              level = lvl_bright_q;
              pat_d = PAT_KEYWORD;
              done  = 1'b1;
            end else begin
              kw_flag_d = 1'b0;
            end
          end
          if (!done) begin
            if (in_q.awareness != AW_CANDIDATE && in_q.awareness != AW_EVENT &&
                pk_d == PK_CONT) begin
              pk_d = PK_NONE;
            end
            if (in_q.direction == DirUnknown && in_q.event_fresh) begin
              unk_flag_d = 1'b1;
              unk_time_d = now;
              pk_d       = PK_NONE;
            end
            if (unk_flag_d) begin
              if ((now - unk_time_d) < {16'd0, unk_flash_ms_q}) begin
                mask  = MaskAll;
                level = bright;
                pat_d = PAT_NONE;
                done  = 1'b1;
              end else begin
                unk_flag_d = 1'b0;
              end
            end
          end
          if (!done) begin
            unique case (in_q.awareness)
              AW_BACKGROUND, AW_COOLDOWN: begin
                acked_d    = 1'b0;
                pk_d       = PK_NONE;
                unk_flag_d = 1'b0;
                pat_d      = PAT_NONE;
                done       = 1'b1;
              end
              AW_NOTICE: begin
                if (in_q.notice_fresh) begin
                  pk_d          = PK_FIXED;
                  pulses_left_d = 2'd1;
                  phase_d       = 1'b0;
                  toggle_time_d = now;
                  pat_d         = PAT_NOTICE;
                end
              end
              AW_CANDIDATE: begin
                pk_d  = PK_CONT;
                pat_d = PAT_CANDIDATE;
              end
              AW_EVENT: begin
                if (in_q.event_fresh) begin
                  acked_d = 1'b0;
                  if (in_q.urgency == URG_CRITICAL) begin
                    pk_d          = PK_CONT;
                    pulses_left_d = 2'd0;
                  end else begin
                    pk_d          = PK_FIXED;
                    pulses_left_d = in_q.urgency + 2'd1;
                  end
                  phase_d       = 1'b0;
                  toggle_time_d = now;
                  pat_d         = pattern_e'({2'b01, in_q.urgency});
                end else if (pk_d == PK_NONE) begin
                  if (in_q.urgency == URG_CRITICAL && !acked_q) begin
                    pk_d = PK_CONT;
                  end else begin
                    mask  = dmask;
                    level = bright;
                    done  = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
          if (!done) begin
            level = bright;
            if (pk_d != PK_NONE) begin
              if ((now - toggle_time_d) >= {16'd0, half_period_ms_q}) begin
                toggle_time_d = now;
                phase_d       = !phase_d;
                // a fixed-count pulse ends on its falling edge
                if (!phase_d && pk_d == PK_FIXED) begin
                  if (pulses_left_d != 2'd0) begin
                    pulses_left_d = pulses_left_d - 2'd1;
                  end
                  if (pulses_left_d == 2'd0) begin
                    pk_d = PK_NONE;
                  end
                end
              end
              mask = phase_d ? dmask : 4'd0;
            end else begin
              mask = dmask;
            end
          end
        end
      end
      CMD_KEYWORD: begin
        kw_flag_d = 1'b1;
        kw_time_d = now;
      end
      CMD_ACK: begin
        acked_d = 1'b1;
        if (pk_q == PK_CONT) begin
          pk_d = PK_NONE;
        end
      end
      CMD_TEST: begin
        acc = tdec.known;
        if (tdec.known && !tdec.light) begin
          manual_d   = 1'b0;
          pk_d       = PK_NONE;
          unk_flag_d = 1'b0;
          pat_d      = PAT_NONE;
          drive      = 1'b1;
        end else if (tdec.light) begin
          manual_d = 1'b1;
          pk_d     = PK_NONE;
          mask     = tdec.mask;
          level    = lvl_bright_q;
          pat_d    = PAT_MANUAL;
          drive    = 1'b1;
        end
      end
      default: ;
    endcase

    res_d.led_mask     = drive ? mask : 4'd0;
    res_d.led_level    = drive ? level : 8'd0;
    res_d.drive_valid  = drive;
    res_d.accepted     = acc;
    res_d.manual_on    = manual_d;
    res_d.pattern_code = pat_d;
  end

endmodule

// File: hw/rtl/lapseq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the LED alert pulse sequencer, attached by bind.
// Depends on lapseq_pkg and the top level led_alert_pulse_sequencer.
module lapseq_checker import lapseq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // a stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_drive_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.drive_valid |->
      out_data_i.led_mask == 4'd0 && out_data_i.led_level == 8'd0)
    else $error("LED drive shown without a drive rewrite");

  a_reject_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.accepted |-> !out_data_i.drive_valid)
    else $error("rejected test character rewrote the drive");

  a_manual_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.pattern_code == PAT_MANUAL |-> out_data_i.manual_on)
    else $error("manual pattern outside manual mode");

endmodule

bind led_alert_pulse_sequencer lapseq_checker u_lapseq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_data_i  (out_chan.data)
);
